// ===== rtl/core/ostt_pkg.sv =====
// Shared types and codes for the one-shot timer table.
package ostt_pkg;

    typedef struct packed {
        logic        req_type;
        logic [31:0] amount_ms;
    } t_req;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] timer_id;
        logic        last_of_run;
    } t_result;

    localparam logic       REQ_CREATE   = 1'b0;
    localparam logic       REQ_TICK     = 1'b1;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_LE
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE,
        ST_TICK,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

// ===== rtl/core/ostt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ostt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ostt_alu.sv =====
// Shared 32-bit unit that forms deadlines and clock sums and tests expiry.
module ostt_alu
    import ostt_pkg::*;
(
    input  t_alu_op     i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_sum,
    output logic        o_le
);

    always_comb begin
        o_sum = '0;
        o_le  = 1'b0;
        unique case (i_op)
            ALU_ADD: o_sum = i_a + i_b;
            ALU_LE:  o_le  = (i_a <= i_b);
            default: o_sum = '0;
        endcase
    end

endmodule

// ===== rtl/core/one_shot_timer_table_unit.sv =====
// Top level of the one-shot timer table: sequencer, table memory and shared unit.
//
// A request is taken when start is high and busy is low. A create writes its
// entry in ST_CREATE, while a rejected create answers from ST_IDLE; a tick
// advances the clock in ST_TICK and, unless the table is empty, the sequencer
// reads the table memory one entry per cycle in ST_SCAN, tests it in the shared
// unit and writes survivors back toward the front of the table, ending in
// ST_FLUSH. Each result beat is shown for exactly one cycle with o_strobe high
// and cannot be held off; results of a tick come in creation order, the final
// one marked by last_of_run. The table memory needs no clearing after reset.
module one_shot_timer_table_unit
    import ostt_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int IDX_W = $clog2(NUM_TIMERS);
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    t_state         r_state, n_state;
    t_req           r_req, n_req;
    logic [31:0]    r_clock, n_clock;
    logic [31:0]    r_next_id, n_next_id;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_scan, n_scan;
    logic [CNT_W-1:0] r_keep, n_keep;
    logic           r_pend_valid, n_pend_valid;
    logic [31:0]    r_pend_id, n_pend_id;
    logic           r_out_valid, n_out_valid;
    t_result        r_out, n_out;

    logic [CNT_W-1:0] scan_inc;
    logic           ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [63:0]    ram_wdata, ram_rdata;
    t_alu_op        alu_op;
    logic [31:0]    alu_a, alu_b, alu_sum;
    logic           alu_le;

    ostt_ram #(
        .WIDTH (64),
        .DEPTH (NUM_TIMERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ostt_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum),
        .o_le  (alu_le)
    );

    assign scan_inc = r_scan + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_clock      <= '0;
            r_next_id    <= 32'd1;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clock      <= n_clock;
            r_next_id    <= n_next_id;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_scan    <= n_scan;
        r_keep    <= n_keep;
        r_pend_id <= n_pend_id;
        r_out     <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_clock      = r_clock;
        n_next_id    = r_next_id;
        n_count      = r_count;
        n_scan       = r_scan;
        n_keep       = r_keep;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = r_keep[IDX_W-1:0];
        ram_wdata    = ram_rdata;
        ram_raddr    = '0;
        alu_op       = ALU_ADD;
        alu_a        = r_clock;
        alu_b        = r_req.amount_ms;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    if (i_req.req_type == REQ_CREATE) begin
                        if (r_count >= CNT_W'(NUM_TIMERS)) begin
                            n_out_valid = 1'b1;
                            n_out       = '{result_kind: KIND_REJECT, timer_id: 32'd0,
                                            last_of_run: 1'b1};
                        end else begin
                            n_state = ST_CREATE;
                        end
                    end else begin
                        n_state = ST_TICK;
                    end
                end
            end
            ST_CREATE: begin
                ram_we      = 1'b1;
                ram_waddr   = r_count[IDX_W-1:0];
                ram_wdata   = {alu_sum, r_next_id};
                n_out_valid = 1'b1;
                n_out       = '{result_kind: KIND_ALLOC, timer_id: r_next_id,
                                last_of_run: 1'b1};
                n_next_id   = r_next_id + 32'd1;
                n_count     = r_count + CNT_W'(1);
                n_state     = ST_IDLE;
            end
            ST_TICK: begin
                n_clock      = alu_sum;
                n_scan       = '0;
                n_keep       = '0;
                n_pend_valid = 1'b0;
                if (r_count == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                alu_op    = ALU_LE;
                alu_a     = ram_rdata[63:32];
                alu_b     = r_clock;
                ram_re    = 1'b1;
                ram_raddr = scan_inc[IDX_W-1:0];
                if (alu_le) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = '{result_kind: KIND_EXPIRED, timer_id: r_pend_id,
                                        last_of_run: 1'b0};
                    end
                    n_pend_valid = 1'b1;
                    n_pend_id    = ram_rdata[31:0];
                end else begin
                    ram_we = 1'b1;
                    n_keep = r_keep + CNT_W'(1);
                end
                n_scan = scan_inc;
                if (scan_inc == r_count) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = '{result_kind: KIND_EXPIRED, timer_id: r_pend_id,
                                    last_of_run: 1'b1};
                end
                n_pend_valid = 1'b0;
                n_count      = r_keep;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== tb/one_shot_timer_table_unit_test.sv =====
// Self-checking testbench for the one-shot timer table: directed and random requests.
`timescale 1ns / 1ps

module one_shot_timer_table_unit_test;
    import ostt_pkg::*;

    localparam int TABLE_DEPTH = 16;

    class timer_table_scoreboard;
        logic [31:0] now_ms;
        logic [31:0] fresh_id;
        logic [31:0] deadline_ms [TABLE_DEPTH];
        logic [31:0] owner_id [TABLE_DEPTH];
        int unsigned live;
        t_result due_results[$];
        int unsigned fail_count;

        function new();
            now_ms = '0;
            fresh_id = 32'd1;
            live = 0;
            fail_count = 0;
        endfunction

        function void push_due(logic [1:0] kind, logic [31:0] id, logic last);
            t_result res;
            res.result_kind = kind;
            res.timer_id = id;
            res.last_of_run = last;
            due_results = {due_results, res};
        endfunction

        function void note_request(t_req r);
            logic [31:0] gone[$];
            int unsigned keep;
            keep = 0;
            if (r.req_type == REQ_CREATE) begin
                if (live >= TABLE_DEPTH) begin
                    push_due(KIND_REJECT, 32'd0, 1'b1);
                end else begin
                    deadline_ms[live] = now_ms + r.amount_ms;
                    owner_id[live] = fresh_id;
                    push_due(KIND_ALLOC, fresh_id, 1'b1);
                    fresh_id = fresh_id + 32'd1;
                    live = live + 1;
                end
            end else begin
                now_ms = now_ms + r.amount_ms;
                for (int i = 0; i < live; i++) begin
                    if (deadline_ms[i] <= now_ms) begin
                        gone = {gone, owner_id[i]};
                    end else begin
                        deadline_ms[keep] = deadline_ms[i];
                        owner_id[keep] = owner_id[i];
                        keep = keep + 1;
                    end
                end
                live = keep;
                for (int k = 0; k < gone.size(); k++) begin
                    push_due(KIND_EXPIRED, gone[k], k == gone.size() - 1);
                end
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result beat: kind %0d id %h last %b",
                             got.result_kind, got.timer_id, got.last_of_run);
                end
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (got.result_kind !== want.result_kind || got.timer_id !== want.timer_id ||
                    got.last_of_run !== want.last_of_run) begin
                    if (fail_count < 10) begin
                        $write("mismatch: expected kind %0d id %h last %b, ",
                               want.result_kind, want.timer_id, want.last_of_run);
                        $display("got kind %0d id %h last %b",
                                 got.result_kind, got.timer_id, got.last_of_run);
                    end
                    fail_count++;
                end
            end
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function void close_out();
            if (due_results.size() != 0) begin
                $display("%0d expected result beats never arrived", due_results.size());
                fail_count += due_results.size();
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_req    i_req;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    timer_table_scoreboard sb;
    int unsigned idle_pct;

    one_shot_timer_table_unit #(
        .NUM_TIMERS(TABLE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_req(i_req),
        .busy(busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // Each result beat is checked at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_result(o_result);
            end
            if (start && !busy) begin
                sb.note_request(i_req);
            end
        end
    end

    function automatic t_req make_req(logic kind, logic [31:0] amount);
        t_req r;
        r.req_type = kind;
        r.amount_ms = amount;
        return r;
    endfunction

    function automatic t_req pick_request();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 55) begin
            if (roll < 80) begin
                return make_req(REQ_CREATE, $urandom_range(0, 200));
            end else begin
                return make_req(REQ_CREATE, $urandom());
            end
        end else begin
            if (roll < 70) begin
                return make_req(REQ_TICK, $urandom_range(0, 100));
            end else if (roll < 85) begin
                return make_req(REQ_TICK, 32'd0);
            end else begin
                return make_req(REQ_TICK, $urandom());
            end
        end
    endfunction

    task automatic send_request(input t_req r);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            i_req = make_req(1'($urandom_range(0, 1)), $urandom());
        end
        @(negedge i_clk);
        start = 1'b1;
        i_req = r;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
    endtask

    initial begin
        #5_000_000;
        $display("one_shot_timer_table_unit_test NOT OK");
        $finish;
    end

    initial begin
        int unsigned phase_pct [4];
        int unsigned sent;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        idle_pct = 0;
        phase_pct = '{0, 76, 6, 0};
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty tick, zero and maximal durations, a full table, a rejection,
        // a tick that expires every entry and a deadline that wrapped early.
        send_request(make_req(REQ_TICK, 32'd0));
        send_request(make_req(REQ_CREATE, 32'd0));
        send_request(make_req(REQ_CREATE, 32'hFFFF_FFF0));
        send_request(make_req(REQ_CREATE, 32'd5));
        send_request(make_req(REQ_TICK, 32'd0));
        send_request(make_req(REQ_TICK, 32'd5));
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
            send_request(make_req(REQ_CREATE, 32'd10));
        end
        send_request(make_req(REQ_CREATE, 32'hFFFF_FFFF));
        send_request(make_req(REQ_TICK, 32'hFFFF_FFF0));
        send_request(make_req(REQ_CREATE, 32'h0000_0020));
        send_request(make_req(REQ_TICK, 32'd0));
        send_request(make_req(REQ_TICK, 32'h0000_000B));
        drain();

        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_pct[p];
            sent = 0;
            while (sent < 94) begin
                if ($urandom_range(0, 19) == 0) begin
                    for (int b = 0; b < TABLE_DEPTH + 1; b++) begin
                        send_request(make_req(REQ_CREATE, $urandom_range(0, 1000)));
                    end
                    sent = sent + TABLE_DEPTH + 1;
                end else begin
                    send_request(pick_request());
                    sent = sent + 1;
                end
            end
            drain();
        end

        sb.close_out();
        if (sb.fail_count == 0) begin
            $display("one_shot_timer_table_unit_test OK");
        end else begin
            $display("one_shot_timer_table_unit_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== one_shot_timer_table_unit.f =====
rtl/core/ostt_pkg.sv
rtl/core/ostt_ram.sv
rtl/core/ostt_alu.sv
rtl/core/one_shot_timer_table_unit.sv
tb/one_shot_timer_table_unit_test.sv
